>>> hdl/windowed_swing_gesture_detector_unit_macros.svh
// Assertion macros for the windowed swing gesture detector.
// Used by the checker module; needs nothing else.
`ifndef WINDOWED_SWING_GESTURE_DETECTOR_UNIT_MACROS_SVH
`define WINDOWED_SWING_GESTURE_DETECTOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSGD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define WSGD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> hdl/wsgd_pkg.sv
// Shared types and constants for the windowed swing gesture detector.
// No dependencies.
package wsgd_pkg;

   localparam int POS_W      = 16;
   localparam int THR_W      = 16;
   localparam int STALE_W    = 16;
   localparam int WLEN_W     = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [THR_W-1:0]   THRESHOLD_RESET = 16'd800;
   localparam logic [STALE_W-1:0] STALE_RESET     = 16'd250;
   localparam logic [WLEN_W-1:0]  WLEN_RESET      = 6'd30;
   localparam logic [STALE_W-1:0] MS_MAX          = 16'hFFFF;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_FRAME = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_STALE     = 2'd1,
      CSR_WLEN      = 2'd2
   } wsgd_csr_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_EVAL = 4'b0100,
      ST_RESP = 4'b1000
   } wsgd_state_type;

endpackage

>>> hdl/windowed_swing_gesture_detector_unit.sv
// Windowed swing gesture detector: one sliding window of L/R pairs, peak-to-peak threshold test.
// Tick: accepted with no response. Unseen frame: response valid in the cycle after acceptance.
// Seen frame: the scan reads the window entries (the new one included) newest first, one per cycle
// from the window RAM's read port; the response goes valid after the scan and evaluation states.
// Not ready from frame acceptance until its response transaction completes.
// Sync reset: control and CSR registers to defaults, window empty; RAM contents are not cleared.
module windowed_swing_gesture_detector_unit #(
   parameter int WINDOW_MAX = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_opcode,
   input  logic                                   req_both_seen,
   input  logic signed [wsgd_pkg::POS_W-1:0]      req_left_pos,
   input  logic signed [wsgd_pkg::POS_W-1:0]      req_right_pos,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_flapping,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [wsgd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [wsgd_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   import wsgd_pkg::*;

   localparam int ADDR_W  = $clog2(WINDOW_MAX);
   localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
   localparam int CMP_W   = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
   localparam int ENTRY_W = 2 * POS_W;
   localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(WINDOW_MAX - 1);
   localparam logic [CMP_W-1:0]  MAX_LEN   = CMP_W'(WINDOW_MAX);
   localparam logic signed [POS_W-1:0] POS_HIGHEST = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_LOWEST  = {1'b1, {(POS_W-1){1'b0}}};

   wsgd_state_type state_ff, state_in;

   logic [THR_W-1:0]   threshold_ff, threshold_in;
   logic [STALE_W-1:0] stale_ff, stale_in;
   logic [WLEN_W-1:0]  wlen_ff, wlen_in;
   logic [STALE_W-1:0] ms_ff, ms_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [ADDR_W-1:0]  slot_ff, slot_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [ADDR_W-1:0]  rd_addr_ff, rd_addr_in;
   logic               dv_ff, dv_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               flap_ff, flap_in;
   logic signed [POS_W-1:0] lo_l_ff, lo_l_in, hi_l_ff, hi_l_in;
   logic signed [POS_W-1:0] lo_r_ff, lo_r_in, hi_r_ff, hi_r_in;

   logic               accept;
   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic signed [POS_W-1:0] rd_left, rd_right;
   logic [CMP_W-1:0]   wlen_ext, eff_len_cmp;
   logic [CNT_W-1:0]   eff_len, fill_clamped, fill_grown;
   logic [ADDR_W-1:0]  next_slot;
   logic               stale_hit;
   logic [POS_W:0]     range_l, range_r;

   assign accept    = req_valid & req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_flapping = flap_ff;

   // Out-of-range lengths: zero acts as one, anything above the store depth as the depth.
   assign wlen_ext    = CMP_W'(wlen_ff);
   assign eff_len_cmp = (wlen_ext == '0) ? CMP_W'(1) :
                        ((wlen_ext > MAX_LEN) ? MAX_LEN : wlen_ext);
   assign eff_len      = CNT_W'(eff_len_cmp);
   assign fill_clamped = (fill_ff > eff_len) ? eff_len : fill_ff;
   assign fill_grown   = (fill_clamped < eff_len) ? fill_clamped + 1'b1 : fill_clamped;
   assign next_slot    = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
   assign stale_hit    = (ms_ff >= stale_ff);

   assign ram_wr_en = accept & (req_opcode == OP_FRAME) & req_both_seen;
   assign ram_rd_en = (state_ff == ST_SCAN) && (rem_ff != '0);
   assign rd_left   = $signed(ram_rd_data[ENTRY_W-1:POS_W]);
   assign rd_right  = $signed(ram_rd_data[POS_W-1:0]);

   // Ranges at one extra bit, so a full-scale swing cannot wrap.
   assign range_l = {hi_l_ff[POS_W-1], hi_l_ff} - {lo_l_ff[POS_W-1], lo_l_ff};
   assign range_r = {hi_r_ff[POS_W-1], hi_r_ff} - {lo_r_ff[POS_W-1], lo_r_ff};

   wsgd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (WINDOW_MAX)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data ({req_left_pos, req_right_pos}),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      threshold_in = threshold_ff;
      stale_in     = stale_ff;
      wlen_in      = wlen_ff;
      ms_in        = ms_ff;
      fill_in      = fill_ff;
      slot_in      = slot_ff;
      rem_in       = rem_ff;
      rd_addr_in   = rd_addr_ff;
      dv_in        = ram_rd_en;
      rsp_valid_in = rsp_valid_ff;
      flap_in      = flap_ff;
      lo_l_in      = lo_l_ff;
      hi_l_in      = hi_l_ff;
      lo_r_in      = lo_r_ff;
      hi_r_in      = hi_r_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_THRESHOLD: threshold_in = csr_wdata;
            CSR_STALE:     stale_in     = csr_wdata;
            CSR_WLEN:      wlen_in      = csr_wdata[WLEN_W-1:0];
            default:       ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_TICK) begin
                  ms_in = (ms_ff == MS_MAX) ? ms_ff : ms_ff + 1'b1;
               end else if (req_both_seen) begin
                  // The new entry was written at slot_ff; the scan walks back from there.
                  ms_in      = '0;
                  slot_in    = next_slot;
                  fill_in    = fill_grown;
                  rem_in     = fill_grown;
                  rd_addr_in = slot_ff;
                  lo_l_in    = POS_HIGHEST;
                  hi_l_in    = POS_LOWEST;
                  lo_r_in    = POS_HIGHEST;
                  hi_r_in    = POS_LOWEST;
                  state_in   = ST_SCAN;
               end else begin
                  flap_in      = 1'b0;
                  rsp_valid_in = 1'b1;
                  if (stale_hit) begin
                     fill_in = '0;
                     slot_in = '0;
                  end
                  state_in = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            if (dv_ff) begin
               if (rd_left < lo_l_ff) lo_l_in = rd_left;
               if (rd_left > hi_l_ff) hi_l_in = rd_left;
               if (rd_right < lo_r_ff) lo_r_in = rd_right;
               if (rd_right > hi_r_ff) hi_r_in = rd_right;
            end
            if (ram_rd_en) begin
               rd_addr_in = (rd_addr_ff == '0) ? LAST_SLOT : rd_addr_ff - 1'b1;
               rem_in     = rem_ff - 1'b1;
            end
            if ((rem_ff == '0) && !dv_ff) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            flap_in      = (range_l > {1'b0, threshold_ff}) &&
                           (range_r > {1'b0, threshold_ff});
            rsp_valid_in = 1'b1;
            // The counter was zeroed by this frame, so this only fires for a zero limit.
            if (stale_hit) begin
               fill_in = '0;
               slot_in = '0;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         threshold_ff <= THRESHOLD_RESET;
         stale_ff     <= STALE_RESET;
         wlen_ff      <= WLEN_RESET;
         ms_ff        <= '0;
         fill_ff      <= '0;
         slot_ff      <= '0;
         rem_ff       <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         threshold_ff <= threshold_in;
         stale_ff     <= stale_in;
         wlen_ff      <= wlen_in;
         ms_ff        <= ms_in;
         fill_ff      <= fill_in;
         slot_ff      <= slot_in;
         rem_ff       <= rem_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      flap_ff    <= flap_in;
      lo_l_ff    <= lo_l_in;
      hi_l_ff    <= hi_l_in;
      lo_r_ff    <= lo_r_in;
      hi_r_ff    <= hi_r_in;
   end

endmodule

>>> hdl/wsgd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module wsgd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/wsgd_checker.sv
// Port-level assertions for the windowed swing gesture detector, bound to the top level.
// Depends on wsgd_pkg and windowed_swing_gesture_detector_unit_macros.svh.
`include "windowed_swing_gesture_detector_unit_macros.svh"

module wsgd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_opcode,
   input logic req_both_seen,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_flapping
);

   import wsgd_pkg::*;

   logic req_txn, rsp_txn;

   assign req_txn = req_valid & req_ready;
   assign rsp_txn = rsp_valid & rsp_ready;

   // A waiting response keeps its value until taken.
   `WSGD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_flapping))

   // No new request is taken while a response is outstanding.
   `WSGD_ASSERT_SAME(a_busy_while_rsp, clock, reset, rsp_valid, !req_ready)

   // A frame without both points seen answers zero on the next cycle.
   `WSGD_ASSERT_NEXT(a_unseen_zero, clock, reset, req_txn && (req_opcode == OP_FRAME) && !req_both_seen, rsp_valid && !rsp_flapping)

   // A tick produces no response and leaves the block ready.
   `WSGD_ASSERT_NEXT(a_tick_silent, clock, reset, req_txn && (req_opcode == OP_TICK), !rsp_valid && req_ready)

   // Once a response transaction completes, the block is ready again.
   `WSGD_ASSERT_NEXT(a_ready_after_rsp, clock, reset, rsp_txn, req_ready && !rsp_valid)

endmodule

bind windowed_swing_gesture_detector_unit wsgd_checker u_wsgd_checker (.*);
